[sv/lli_pkg.sv]
// Shared types and constants for the 2-D line intersection block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package lli_pkg;

    localparam int COORD_W       = 16;               // input coordinate width
    localparam int FRAC_BITS_DEF = 16;               // default result fraction bits
    localparam int OUT_W         = 48;               // result coordinate width
    localparam int AB_W          = COORD_W + 1;      // A = dy, B = -dx
    localparam int C_W           = 2 * COORD_W + 2;  // C = A*x + B*y
    localparam int D_W           = 2 * COORD_W + 3;  // determinant
    localparam int N_W           = 3 * COORD_W + 4;  // Cramer numerators
    localparam int FRONT_LAT     = 4;                // front pipeline stages
    localparam int FL_CW         = $clog2(FRONT_LAT + 1);
    localparam int QUEUE_DEPTH_DEF = 8;              // must be a power of two

    typedef struct packed {
        logic signed [COORD_W-1:0] first_start_x;
        logic signed [COORD_W-1:0] first_start_y;
        logic signed [COORD_W-1:0] first_end_x;
        logic signed [COORD_W-1:0] first_end_y;
        logic signed [COORD_W-1:0] second_start_x;
        logic signed [COORD_W-1:0] second_start_y;
        logic signed [COORD_W-1:0] second_end_x;
        logic signed [COORD_W-1:0] second_end_y;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] cross_x;
        logic signed [OUT_W-1:0] cross_y;
        logic                    parallel;
        logic                    saturated;
    } t_out_item;

    // Classified job handed from front to back: magnitudes plus signs.
    typedef struct packed {
        logic [N_W-1:0] num_x;
        logic [N_W-1:0] num_y;
        logic           neg_x;
        logic           neg_y;
        logic [D_W-1:0] den;
        logic           parallel;
    } t_job;

    typedef struct packed {
        logic [FL_CW-1:0] inflight;
    } t_front_stat;

endpackage
`default_nettype wire

[sv/line_line_intersection_2d_top.sv]
// Top level of the 2-D line intersection block (Cramer's rule).
// Depends on lli_pkg, lli_front, lli_queue, lli_back.
`timescale 1ns / 1ps
`default_nettype none
// Each transaction carries two lines, each as two signed 16-bit points, and
// returns one result: the intersection in signed fixed point with FRAC_BITS
// fraction bits (Q31.16 by default), truncated toward zero and clamped to
// 48 bits with o_result.saturated set, or parallel=1 with a zero point when
// the determinant is zero. A transaction is taken on any edge where start is
// high and busy is low; one can be issued every cycle while busy stays low.
// Every result appears on o_result for a single cycle with o_done high and
// cannot be held off, so the consumer must always sample it. A result passes
// through four front stages, the job queue with its registered read, the
// pipelined divider with one stage per quotient bit and the result register.
// Results come back in issue order.
// busy rises only if the job queue plus the front pipeline could fill, which
// does not occur in normal streaming since the back end drains the queue
// every cycle.
module line_line_intersection_2d_top
    import lli_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,   // 0 .. 24
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF  // power of two, > FRONT_LAT
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_in_item  i_item,
    output logic           o_done,
    output t_out_item      o_result
);

    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    logic             front_vld;
    t_job             front_job;
    t_front_stat      front_stat;
    t_job             q_job;
    logic             q_vld;
    logic             q_empty;
    logic [QC_W-1:0]  q_count;
    logic             take;

    // a transaction enters the front pipeline on start with busy low
    assign take = start & ~busy;

    // hold off new work when queue entries plus in-flight front items
    // could exceed the queue
    assign busy = (int'(front_stat.inflight) + int'(q_count)) >= QUEUE_DEPTH;

    lli_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_vld(take), .i_item(i_item),
        .o_vld(front_vld), .o_job(front_job), .o_stat(front_stat)
    );

    // back end never stalls, so the queue head is popped whenever present;
    // the popped job reaches the back end from the queue's read register in the next cycle
    lli_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(front_vld), .i_job(front_job),
        .i_pop(~q_empty), .o_job(q_job), .o_vld(q_vld),
        .o_empty(q_empty), .o_count(q_count)
    );

    lli_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_vld(q_vld), .i_job(q_job),
        .o_done(o_done), .o_result(o_result)
    );

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.parallel |->
            o_result.cross_x == '0 && o_result.cross_y == '0 &&
            !o_result.saturated)
        else $error("parallel result carries a point or saturation");
    a_busy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_vld |-> q_count != QC_W'(QUEUE_DEPTH))
        else $error("front pushed into a full queue");

endmodule
`default_nettype wire

[sv/lli_front.sv]
// Front pipeline: line coefficients, determinant, numerators, sign split.
// Depends on lli_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lli_front
    import lli_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire t_in_item    i_item,
    output logic             o_vld,
    output t_job             o_job,
    output t_front_stat      o_stat
);

    logic [FRONT_LAT-1:0] r_vld;

    // stage 1
    logic signed [AB_W-1:0]    r1_a1, r1_b1, r1_a2, r1_b2;
    logic signed [COORD_W-1:0] r1_x1, r1_y1, r1_x3, r1_y3;
    // stage 2
    logic signed [AB_W-1:0]    r2_a1, r2_b1, r2_a2, r2_b2;
    logic signed [C_W-1:0]     r2_c1, r2_c2;
    logic signed [D_W-1:0]     r2_det;
    // stage 3
    logic signed [N_W-1:0]     r3_p0, r3_p1, r3_p2, r3_p3;
    logic signed [D_W-1:0]     r3_det;
    // stage 4
    t_job                      r4_job;

    logic signed [C_W-1:0] n_m0, n_m1, n_m2, n_m3;
    logic signed [D_W-1:0] n_d0, n_d1;
    logic signed [N_W-1:0] n_nx, n_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[FRONT_LAT-2:0], i_vld};
        end
    end

    always_comb begin
        n_m0 = r1_a1 * r1_x1;
        n_m1 = r1_b1 * r1_y1;
        n_m2 = r1_a2 * r1_x3;
        n_m3 = r1_b2 * r1_y3;
        n_d0 = r1_a1 * r1_b2;
        n_d1 = r1_a2 * r1_b1;
        n_nx = r3_p0 - r3_p1;
        n_ny = r3_p2 - r3_p3;
    end

    always_ff @(posedge i_clk) begin
        r1_a1 <= AB_W'(i_item.first_end_y)  - AB_W'(i_item.first_start_y);
        r1_b1 <= AB_W'(i_item.first_start_x) - AB_W'(i_item.first_end_x);
        r1_a2 <= AB_W'(i_item.second_end_y)  - AB_W'(i_item.second_start_y);
        r1_b2 <= AB_W'(i_item.second_start_x) - AB_W'(i_item.second_end_x);
        r1_x1 <= i_item.first_start_x;
        r1_y1 <= i_item.first_start_y;
        r1_x3 <= i_item.second_start_x;
        r1_y3 <= i_item.second_start_y;

        r2_a1  <= r1_a1;
        r2_b1  <= r1_b1;
        r2_a2  <= r1_a2;
        r2_b2  <= r1_b2;
        r2_c1  <= n_m0 + n_m1;
        r2_c2  <= n_m2 + n_m3;
        r2_det <= n_d0 - n_d1;

        r3_p0  <= r2_b2 * r2_c1;
        r3_p1  <= r2_b1 * r2_c2;
        r3_p2  <= r2_a1 * r2_c2;
        r3_p3  <= r2_a2 * r2_c1;
        r3_det <= r2_det;

        r4_job.num_x    <= n_nx[N_W-1] ? N_W'(-n_nx) : N_W'(n_nx);
        r4_job.num_y    <= n_ny[N_W-1] ? N_W'(-n_ny) : N_W'(n_ny);
        r4_job.neg_x    <= n_nx[N_W-1] ^ r3_det[D_W-1];
        r4_job.neg_y    <= n_ny[N_W-1] ^ r3_det[D_W-1];
        r4_job.den      <= r3_det[D_W-1] ? D_W'(-r3_det) : D_W'(r3_det);
        r4_job.parallel <= (r3_det == '0);
    end

    assign o_vld           = r_vld[FRONT_LAT-1];
    assign o_job           = r4_job;
    assign o_stat.inflight = FL_CW'($countones(r_vld));

endmodule
`default_nettype wire

[sv/lli_queue.sv]
// Small FIFO of classified jobs between front and back.
// Depends on lli_pkg. DEPTH must be a power of two.
`timescale 1ns / 1ps
`default_nettype none
module lli_queue
    import lli_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire t_job                       i_job,
    input  wire logic                       i_pop,
    output t_job                            o_job,
    output logic                            o_vld,
    output logic                            o_empty,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    t_job             r_job;
    logic             r_vld;

    // popped head lands in r_job, valid in the cycle after the pop
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
        if (i_pop) begin
            r_job <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_vld   <= 1'b0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
            r_vld   <= i_pop;
        end
    end

    assign o_job   = r_job;
    assign o_vld   = r_vld;
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count != CNT_W'(DEPTH))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("job queue underflow");

endmodule
`default_nettype wire

[sv/lli_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Depends on lli_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lli_div
    import lli_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SB_W      = 1
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_vld,
    input  wire logic [N_W-1:0]          i_num,
    input  wire logic [D_W-1:0]          i_den,
    input  wire logic [SB_W-1:0]         i_sb,
    output logic                         o_vld,
    output logic [N_W+FRAC_BITS-1:0]     o_quo,
    output logic [SB_W-1:0]              o_sb
);

    localparam int QW = N_W + FRAC_BITS;

    logic [QW:0]       r_vld;
    logic [D_W-1:0]    r_rem [QW+1];
    logic [QW-1:0]     r_dvd [QW+1];
    logic [QW-1:0]     r_quo [QW+1];
    logic [D_W-1:0]    r_den [QW+1];
    logic [SB_W-1:0]   r_sb  [QW+1];

    logic [D_W:0]      trial [QW];
    logic [QW-1:0]     ge;
    logic [D_W-1:0]    n_rem [QW];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            trial[k] = {r_rem[k], r_dvd[k][QW-1]};
            ge[k]    = trial[k] >= {1'b0, r_den[k]};
            n_rem[k] = ge[k] ? D_W'(trial[k] - {1'b0, r_den[k]}) : D_W'(trial[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QW-1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_dvd[0] <= QW'(i_num) << FRAC_BITS;
        r_quo[0] <= '0;
        r_den[0] <= i_den;
        r_sb[0]  <= i_sb;
        for (int k = 0; k < QW; k++) begin
            r_rem[k+1] <= n_rem[k];
            r_dvd[k+1] <= r_dvd[k] << 1;
            r_quo[k+1] <= {r_quo[k][QW-2:0], ge[k]};
            r_den[k+1] <= r_den[k];
            r_sb[k+1]  <= r_sb[k];
        end
    end

    assign o_vld = r_vld[QW];
    assign o_quo = r_quo[QW];
    assign o_sb  = r_sb[QW];

endmodule
`default_nettype wire

[sv/lli_back.sv]
// Back end: two dividers, sign restore, saturation, result register.
// Depends on lli_pkg and lli_div.
`timescale 1ns / 1ps
`default_nettype none
module lli_back
    import lli_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_vld,
    input  wire t_job        i_job,
    output logic             o_done,
    output t_out_item        o_result
);

    localparam int QW = N_W + FRAC_BITS;

    logic          x_vld, y_vld;
    logic [QW-1:0] x_quo, y_quo;
    logic [1:0]    x_sb;
    logic          y_sb;
    logic [QW-1:0] lim_x, lim_y;
    logic          sat_x, sat_y;
    logic [OUT_W-1:0] mag_x, mag_y;

    logic      r_done;
    t_out_item r_res;

    lli_div #(.FRAC_BITS(FRAC_BITS), .SB_W(2)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(i_vld),
        .i_num(i_job.num_x), .i_den(i_job.den),
        .i_sb({i_job.parallel, i_job.neg_x}),
        .o_vld(x_vld), .o_quo(x_quo), .o_sb(x_sb)
    );

    lli_div #(.FRAC_BITS(FRAC_BITS), .SB_W(1)) u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(i_vld),
        .i_num(i_job.num_y), .i_den(i_job.den),
        .i_sb(i_job.neg_y),
        .o_vld(y_vld), .o_quo(y_quo), .o_sb(y_sb)
    );

    // limit is 2^47-1 for positive results, 2^47 for negative
    always_comb begin
        lim_x = (QW'(1) << (OUT_W - 1)) - QW'(!x_sb[0]);
        lim_y = (QW'(1) << (OUT_W - 1)) - QW'(!y_sb);
        sat_x = x_quo > lim_x;
        sat_y = y_quo > lim_y;
        mag_x = sat_x ? OUT_W'(lim_x) : OUT_W'(x_quo);
        mag_y = sat_y ? OUT_W'(lim_y) : OUT_W'(y_quo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= x_vld & y_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_sb[1]) begin
            r_res.cross_x   <= '0;
            r_res.cross_y   <= '0;
            r_res.parallel  <= 1'b1;
            r_res.saturated <= 1'b0;
        end else begin
            r_res.cross_x   <= x_sb[0] ? -mag_x : mag_x;
            r_res.cross_y   <= y_sb    ? -mag_y : mag_y;
            r_res.parallel  <= 1'b0;
            r_res.saturated <= sat_x | sat_y;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for line_line_intersection_2d_top.
// Depends on lli_pkg and the block RTL; predicts each result from exact wide math.
`timescale 1ns / 1ps
module testbench;
    import lli_pkg::*;

    localparam int WDOG_LIMIT = 4000;   // idle cycles with no transaction
    localparam int DRAIN_CYC  = 120;    // drain cycles, more than the block's latency

    // Expected intersections, oldest first, plus the exact predictor.
    class cross_board;
        t_out_item pending[$];
        int errors;
        int checked;
        int n_par;
        int n_sat;

        function new();
            errors = 0;
            checked = 0;
            n_par = 0;
            n_sat = 0;
        endfunction

        // Fixed-point quotient, truncated toward zero and clamped to OUT_W bits.
        function logic [OUT_W-1:0] fx_div(logic signed [127:0] num,
                                           logic signed [127:0] den, ref bit sat);
            logic neg;
            logic [127:0] n, d, q, lim;
            neg = num[127] ^ den[127];
            n = num[127] ? -num : num;
            d = den[127] ? -den : den;
            q = (n << FRAC_BITS_DEF) / d;
            lim = neg ? (128'd1 << (OUT_W - 1)) : (128'd1 << (OUT_W - 1)) - 1;
            if (q > lim) begin
                sat = 1'b1;
                q = lim;
            end
            if (neg) q = -q;
            return q[OUT_W-1:0];
        endfunction

        function void note_line_pair(t_in_item it);
            logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
            logic signed [127:0] a1, b1, a2, b2, c1, c2, det;
            t_out_item r;
            bit sat;
            x1 = it.first_start_x;  y1 = it.first_start_y;
            x2 = it.first_end_x;    y2 = it.first_end_y;
            x3 = it.second_start_x; y3 = it.second_start_y;
            x4 = it.second_end_x;   y4 = it.second_end_y;
            a1 = y2 - y1; b1 = x1 - x2;
            a2 = y4 - y3; b2 = x3 - x4;
            c1 = a1 * x1 + b1 * y1;
            c2 = a2 * x3 + b2 * y3;
            det = a1 * b2 - a2 * b1;
            sat = 1'b0;
            r = '0;
            if (det == 0) begin
                r.parallel = 1'b1;
                n_par++;
            end else begin
                r.cross_x = fx_div(b2 * c1 - b1 * c2, det, sat);
                r.cross_y = fx_div(a1 * c2 - a2 * c1, det, sat);
                r.saturated = sat;
                if (sat) n_sat++;
            end
            pending.push_back(r);
        endfunction

        task report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] exp);
            errors++;
            $display("mismatch #%0d %s: got %h expected %h", checked, what, got, exp);
        endtask

        task check_cross(t_out_item got);
            t_out_item exp;
            if (pending.size() == 0) begin
                report("unexpected result, cross_x", got.cross_x, '0);
                return;
            end
            exp = pending.pop_front();
            if (got.cross_x !== exp.cross_x) report("cross_x", got.cross_x, exp.cross_x);
            if (got.cross_y !== exp.cross_y) report("cross_y", got.cross_y, exp.cross_y);
            if (got.parallel !== exp.parallel)
                report("parallel", got.parallel, exp.parallel);
            if (got.saturated !== exp.saturated)
                report("saturated", got.saturated, exp.saturated);
            checked++;
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_done;
    t_out_item o_result;

    cross_board board;
    int        wdog;
    int        sent;
    int        idle_pct;

    line_line_intersection_2d_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_done  (o_done),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // Results cannot be held off: sample every strobe.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) board.check_cross(o_result);
    end

    // Watchdog: ends the run if neither side moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            wdog <= 0;
        end else if (wdog >= WDOG_LIMIT) begin
            $display("timeout waiting for a transaction");
            $display("[line_line_intersection_2d_top] ERROR");
            $finish;
        end else begin
            wdog <= wdog + 1;
        end
    end

    // Present one transaction; start stays high until it is taken.
    task send_lines(t_in_item it);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        board.note_line_pair(it);
        sent++;
    endtask

    function automatic t_in_item lines_of(int ax, int ay, int bx, int by,
                                          int cx, int cy, int dx, int dy);
        t_in_item it;
        it.first_start_x  = ax[15:0]; it.first_start_y  = ay[15:0];
        it.first_end_x    = bx[15:0]; it.first_end_y    = by[15:0];
        it.second_start_x = cx[15:0]; it.second_start_y = cy[15:0];
        it.second_end_x   = dx[15:0]; it.second_end_y   = dy[15:0];
        return it;
    endfunction

    // Random pair: mostly crossing lines of assorted scale, plus parallel,
    // degenerate and nearly parallel (clamping) shapes.
    function automatic t_in_item random_lines();
        t_in_item it;
        int kind, sx, sy, ox, oy, span;
        kind = $urandom_range(9);
        it = {$urandom, $urandom, $urandom, $urandom};
        span = (kind < 3) ? 15 : 255;
        if (kind < 6) begin
            it = lines_of($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                          $urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                          $urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                          $urandom_range(2 * span) - span, $urandom_range(2 * span) - span);
        end else if (kind == 6) begin
            // shifted copy of line one
            sx = $urandom_range(2000) - 1000; sy = $urandom_range(2000) - 1000;
            ox = $urandom_range(2000) - 1000; oy = $urandom_range(2000) - 1000;
            it.second_start_x = it.first_start_x + ox[15:0];
            it.second_start_y = it.first_start_y + oy[15:0];
            it.second_end_x   = it.first_start_x + ox[15:0] + sx[15:0];
            it.second_end_y   = it.first_start_y + oy[15:0] + sy[15:0];
            it.first_end_x    = it.first_start_x + sx[15:0];
            it.first_end_y    = it.first_start_y + sy[15:0];
        end else if (kind == 7) begin
            it.first_end_x = it.first_start_x;
            it.first_end_y = it.first_start_y;
        end else if (kind == 8) begin
            // directions differing by at most one step: tiny or zero determinant
            sx = $urandom_range(65535) - 32768;
            it = lines_of(-32768, sx, 32767, sx + 1,
                          -32768, -sx, 32767, -sx + $urandom_range(2));
        end
        return it;
    endfunction

    initial begin
        board    = new();
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_item   = '0;
        wdog     = 0;
        sent     = 0;
        idle_pct = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, axis crossings, parallel, degenerate, clamping.
        send_lines(lines_of(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_lines(lines_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_lines(lines_of(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        send_lines(lines_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_lines(lines_of(0, 0, 3, 0, 1, 1, 2, 7));
        send_lines(lines_of(0, 0, 1, 1, 0, 1, 1, 2));
        send_lines(lines_of(0, 0, 2, 2, 1, 1, 3, 3));
        send_lines(lines_of(5, 5, 5, 5, 0, 0, 1, 0));
        send_lines(lines_of(-32768, -32768, 32767, -32767, -32768, 32767, 32767, 32767));
        send_lines(lines_of(-32768, -32768, 32767, -32767, -32768, -32767, 32767, -32768));
        send_lines(lines_of(-32768, 32767, 32767, 32766, -32768, 32766, 32767, 32767));
        send_lines(lines_of(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32767));
        send_lines(lines_of(-1, -1, 0, 2, 3, -1, -2, 0));
        send_lines(lines_of(1, 0, -2, 3, -7, 1, 5, -4));
        send_lines(lines_of(-21846, 21845, 21845, -21846, 21845, 21845, -21846, -21846));
        send_lines(lines_of(32767, -32768, -32768, 32767, 0, 0, 32767, 32767));

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 6 : (ph == 1) ? 87 : 0;
            repeat (200) send_lines(random_lines());
        end
        start <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        $display("%0d line pairs sent, %0d results checked (%0d parallel, %0d clamped)",
                 sent, board.checked, board.n_par, board.n_sat);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("[line_line_intersection_2d_top] OK");
        end else begin
            $display("[line_line_intersection_2d_top] ERROR");
        end
        $finish;
    end
endmodule

[filelist.f]
sv/lli_pkg.sv
sv/lli_front.sv
sv/lli_queue.sv
sv/lli_div.sv
sv/lli_back.sv
sv/line_line_intersection_2d_top.sv
dv/testbench.sv
